/* src/scba_pkg.sv */
// Shared types, constants and helper functions of the size-class block allocator.
package scba_pkg;

    localparam int WORKERS          = 16;
    localparam int NUM_CLASSES      = 6;
    localparam int LIST_DEPTH       = 64;
    localparam int MAX_BLOCKS_LIMIT = 64;
    localparam int PROBE_SPAN       = 4;

    localparam int WID_W   = 4;
    localparam int CLS_W   = 3;
    localparam int OFF_W   = 40;
    localparam int SIZE_W  = 22;
    localparam int REQ_W   = 32;
    localparam int CAP_W   = 40;
    localparam int ALIGN_W = 21;
    localparam int MAXB_W  = 7;
    localparam int ACTW_W  = 5;
    localparam int HP_W    = 41;

    localparam int LIST_N      = WORKERS * NUM_CLASSES;
    localparam int LIST_W      = $clog2(LIST_N);
    localparam int SLOT_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int STORE_DEPTH = LIST_N * LIST_DEPTH;
    localparam int PEND_AW     = $clog2(MAX_BLOCKS_LIMIT);
    localparam int PCNT_W      = $clog2(MAX_BLOCKS_LIMIT + 1);
    localparam int PROBE_W     = $clog2(PROBE_SPAN + 2);

    localparam int CHUNK_SH = 20;
    localparam int REST_W   = CHUNK_SH;
    localparam int FULL_W   = REQ_W - CHUNK_SH;
    localparam int TOTAL_W  = FULL_W + 1;
    localparam int CLSB_W   = 21;
    localparam int DEF_ALIGN = 4096;

    localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(1073741824);
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(4096);
    localparam logic [MAXB_W-1:0]  MAXB_RESET  = MAXB_W'(64);
    localparam logic [ACTW_W-1:0]  ACTW_RESET  = ACTW_W'(16);

    typedef enum logic [1:0] {
        CFG_CAPACITY   = 2'd0,
        CFG_ALIGNMENT  = 2'd1,
        CFG_MAX_BLOCKS = 2'd2,
        CFG_WORKERS    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TOO_MANY   = 3'd2,
        ST_BAD_WORKER = 3'd3,
        ST_LIST_FULL  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHUNK,
        S_PROBE_CHK,
        S_POP_WAIT,
        S_HEAP,
        S_GOT,
        S_RB_NEXT,
        S_RB_LATCH,
        S_RB_WR,
        S_EMIT_ONE,
        S_OUT_RD,
        S_OUT_WAIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        AL_LOAD,
        AL_DIV,
        AL_MUL,
        AL_DONE
    } align_state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
    } store_ent_t;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
    } blk_t;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [CNT_W-1:0]  count;
    } meta_t;

    typedef struct packed {
        logic              rd_en;
        logic [LIST_W-1:0] rd_addr;
        logic              wr_en;
        logic [LIST_W-1:0] wr_addr;
        meta_t             wr_data;
    } meta_req_t;

    function automatic logic [CLSB_W-1:0] class_size(input logic [CLS_W-1:0] c);
        logic [CLSB_W-1:0] r;
        case (c)
            3'd0:    r = CLSB_W'(4096);
            3'd1:    r = CLSB_W'(16384);
            3'd2:    r = CLSB_W'(32768);
            3'd3:    r = CLSB_W'(65536);
            3'd4:    r = CLSB_W'(131072);
            default: r = CLSB_W'(1048576);
        endcase
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] class_for(input logic [REST_W-1:0] sz);
        logic [CLS_W-1:0] r;
        logic             hit;
        r   = CLS_W'(NUM_CLASSES - 1);
        hit = 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (!hit && class_size(CLS_W'(i)) >= {1'b0, sz}) begin
                r   = CLS_W'(i);
                hit = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [LIST_W-1:0] list_index(input logic [WID_W-1:0] w,
                                                     input logic [CLS_W-1:0] c);
        return LIST_W'(LIST_W'(w) * LIST_W'(NUM_CLASSES)) + LIST_W'(c);
    endfunction

endpackage

/* src/size_class_block_allocator.sv */
// Top level of the size-class block allocator: control sequencer, heap pointer, configuration.
//
//   channel | ports        | beat
//   --------+--------------+---------------------------------------------
//   input   | s_valid/ready| one allocate or free request
//   output  | m_valid/ready| one block result or one status result
//   config  | cfg_we       | one register write, no handshake
//
// An allocate takes each chunk in turn: it starts, reads the meta memory once per probed
// list and then takes the block; the results are then read back from the pending-block
// memory, and rollback returns each pending block to its list. After reset and after each
// alignment write the class size table is rebuilt while no request is taken. Output stalls
// hold the sequencer.
module size_class_block_allocator
    import scba_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [WID_W-1:0]   s_worker,
    input  logic [REQ_W-1:0]   s_request_size,
    input  logic [OFF_W-1:0]   s_block_offset,
    input  logic [SIZE_W-1:0]  s_block_length,
    input  logic [CLS_W-1:0]   s_size_class,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [OFF_W-1:0]   m_block_offset_out,
    output logic [SIZE_W-1:0]  m_block_size_out,
    output logic [CLS_W-1:0]   m_class_out,
    output logic               m_last,
    output logic [CAP_W-1:0]   m_remaining_space,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CAP_W-1:0]   cfg_data
);

    ctl_state_t         state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [MAXB_W-1:0]  maxb_reg;
    logic [ACTW_W-1:0]  actw_reg;
    logic [HP_W-1:0]    hp_reg, hp_next;
    logic [WID_W-1:0]   worker_reg, worker_next;
    logic               free_reg, free_next;
    logic [FULL_W-1:0]  full_reg, full_next;
    logic [REST_W-1:0]  rest_reg, rest_next;
    logic [TOTAL_W-1:0] k_reg, k_next;
    logic [PCNT_W-1:0]  cnt_reg, cnt_next;
    logic [PCNT_W-1:0]  j_reg, j_next;
    logic [WID_W-1:0]   pw_reg, pw_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    blk_t               b_reg, b_next;
    blk_t               pb_reg, pb_next;
    logic               push_b_reg, push_b_next;
    status_t            status_reg, status_next;

    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [OFF_W-1:0]   m_off_reg;
    logic [SIZE_W-1:0]  m_size_reg;
    logic [CLS_W-1:0]   m_cls_reg;
    logic               m_last_reg;
    logic [CAP_W-1:0]   m_rem_reg;

    logic               out_load;
    status_t            out_status;
    blk_t               out_blk;
    logic               out_last;

    meta_req_t          mreq;
    meta_t              md;
    logic               st_we, st_re;
    logic [LIST_W+SLOT_W-1:0] st_waddr, st_raddr;
    store_ent_t         st_wdata, srd;
    logic               pd_we, pd_re;
    logic [PEND_AW-1:0] pd_waddr, pd_raddr;
    blk_t               prd;

    logic               align_start, align_rdy;
    logic [SIZE_W-1:0]  asz;

    logic [ACTW_W-1:0]  nw;
    logic [MAXB_W-1:0]  limit;
    logic               wok, wok_in, accept, out_free;
    logic [CLS_W-1:0]   chunk_cls;
    logic [WID_W-1:0]   pw_step;
    logic [PROBE_W-1:0] probe_inc;
    logic               probe_more;
    logic [TOTAL_W-1:0] total;
    logic               fits;
    logic [HP_W-1:0]    room;
    logic [LIST_W-1:0]  l_probe, l_push;
    logic               out_is_last;

    assign nw      = (actw_reg > ACTW_W'(WORKERS)) ? ACTW_W'(WORKERS) : actw_reg;
    assign limit   = (maxb_reg > MAXB_W'(MAX_BLOCKS_LIMIT)) ? MAXB_W'(MAX_BLOCKS_LIMIT)
                                                           : maxb_reg;
    assign wok     = ACTW_W'(worker_reg) < nw;
    assign wok_in  = ACTW_W'(s_worker) < nw;
    assign s_ready = (state_reg == S_IDLE) && align_rdy;
    assign accept  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign chunk_cls  = (k_reg < TOTAL_W'(full_reg)) ? CLS_W'(NUM_CLASSES - 1)
                                                     : class_for(rest_reg);
    assign pw_step    = (ACTW_W'(pw_reg) + ACTW_W'(1) == nw) ? '0 : pw_reg + WID_W'(1);
    assign probe_inc  = probe_reg + PROBE_W'(1);
    assign probe_more = (probe_inc <= PROBE_W'(PROBE_SPAN)) && (ACTW_W'(probe_inc) < nw);
    assign total      = TOTAL_W'(full_reg) + TOTAL_W'(rest_reg != '0);
    assign room       = {1'b0, cap_reg} - hp_reg;
    assign fits       = (hp_reg <= {1'b0, cap_reg}) && (HP_W'(asz) <= room);
    assign l_probe    = list_index(pw_reg, cls_reg);
    assign l_push     = list_index(worker_reg, pb_reg.cls);
    assign out_is_last = (j_reg + PCNT_W'(1)) == cnt_reg;
    assign align_start = cfg_we && (cfg_index == CFG_ALIGNMENT);

    scba_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (align_start),
        .alignment (align_reg),
        .cls       (cls_reg),
        .asz       (asz),
        .ready     (align_rdy)
    );

    scba_meta u_meta (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rdata   (md)
    );

    scba_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH ($bits(store_ent_t))
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (srd)
    );

    scba_ram #(
        .DEPTH (MAX_BLOCKS_LIMIT),
        .WIDTH ($bits(blk_t))
    ) u_pend (
        .aclk  (aclk),
        .we    (pd_we),
        .waddr (pd_waddr),
        .wdata (b_reg),
        .re    (pd_re),
        .raddr (pd_raddr),
        .rdata (prd)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_action) begin
                        state_next = (!wok_in || s_size_class >= CLS_W'(NUM_CLASSES))
                                     ? S_EMIT_ONE : S_RB_WR;
                    end else begin
                        state_next = (s_request_size == '0) ? S_EMIT_ONE : S_CHUNK;
                    end
                end
            end
            S_CHUNK:     state_next = wok ? S_PROBE_CHK : S_HEAP;
            S_PROBE_CHK: begin
                if (md.count != '0) begin
                    state_next = S_POP_WAIT;
                end else begin
                    state_next = probe_more ? S_PROBE_CHK : S_HEAP;
                end
            end
            S_POP_WAIT:  state_next = S_GOT;
            S_HEAP:      state_next = fits ? S_GOT : S_RB_NEXT;
            S_GOT: begin
                if (cnt_reg >= limit) begin
                    state_next = S_RB_NEXT;
                end else if (k_reg + TOTAL_W'(1) == total) begin
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_CHUNK;
                end
            end
            S_RB_NEXT: begin
                if (!wok) begin
                    state_next = S_EMIT_ONE;
                end else if (j_reg < cnt_reg) begin
                    state_next = S_RB_LATCH;
                end else if (push_b_reg) begin
                    state_next = S_RB_WR;
                end else begin
                    state_next = S_EMIT_ONE;
                end
            end
            S_RB_LATCH:  state_next = S_RB_WR;
            S_RB_WR:     state_next = free_reg ? S_EMIT_ONE : S_RB_NEXT;
            S_EMIT_ONE:  state_next = out_free ? S_IDLE : S_EMIT_ONE;
            S_OUT_RD:    state_next = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (out_free) begin
                    state_next = out_is_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        hp_next     = hp_reg;
        worker_next = worker_reg;
        free_next   = free_reg;
        full_next   = full_reg;
        rest_next   = rest_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        j_next      = j_reg;
        pw_next     = pw_reg;
        probe_next  = probe_reg;
        cls_next    = cls_reg;
        b_next      = b_reg;
        pb_next     = pb_reg;
        push_b_next = push_b_reg;
        status_next = status_reg;
        mreq        = '0;
        st_we       = 1'b0;
        st_waddr    = {l_push, md.head + md.count[SLOT_W-1:0]};
        st_wdata    = '{size: pb_reg.size, off: pb_reg.off};
        st_re       = 1'b0;
        st_raddr    = {l_probe, md.head};
        pd_we       = 1'b0;
        pd_waddr    = cnt_reg[PEND_AW-1:0];
        pd_re       = 1'b0;
        pd_raddr    = j_reg[PEND_AW-1:0];
        out_load    = 1'b0;
        out_status  = status_reg;
        out_blk     = '0;
        out_last    = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    worker_next = s_worker;
                    free_next   = s_action;
                    status_next = ST_OK;
                    full_next   = s_request_size[REQ_W-1:CHUNK_SH];
                    rest_next   = s_request_size[REST_W-1:0];
                    k_next      = '0;
                    cnt_next    = '0;
                    j_next      = '0;
                    push_b_next = 1'b0;
                    pb_next     = '{cls: s_size_class, size: s_block_length,
                                    off: s_block_offset};
                    if (s_action && !wok_in) begin
                        status_next = ST_BAD_WORKER;
                    end
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = list_index(s_worker, s_size_class);
                end
            end
            S_CHUNK: begin
                cls_next     = chunk_cls;
                pw_next      = worker_reg;
                probe_next   = '0;
                mreq.rd_en   = wok;
                mreq.rd_addr = list_index(worker_reg, chunk_cls);
            end
            S_PROBE_CHK: begin
                if (md.count != '0) begin
                    st_re         = 1'b1;
                    mreq.wr_en    = 1'b1;
                    mreq.wr_addr  = l_probe;
                    mreq.wr_data  = '{head: md.head + SLOT_W'(1),
                                      count: md.count - CNT_W'(1)};
                end else if (probe_more) begin
                    pw_next      = pw_step;
                    probe_next   = probe_inc;
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = list_index(pw_step, cls_reg);
                end
            end
            S_POP_WAIT: begin
                b_next = '{cls: cls_reg, size: srd.size, off: srd.off};
            end
            S_HEAP: begin
                if (fits) begin
                    b_next  = '{cls: cls_reg, size: asz, off: hp_reg[OFF_W-1:0]};
                    hp_next = hp_reg + HP_W'(asz);
                end else begin
                    status_next = ST_NO_SPACE;
                    j_next      = '0;
                    push_b_next = 1'b0;
                end
            end
            S_GOT: begin
                if (cnt_reg >= limit) begin
                    status_next = ST_TOO_MANY;
                    j_next      = '0;
                    push_b_next = 1'b1;
                end else begin
                    pd_we    = 1'b1;
                    cnt_next = cnt_reg + PCNT_W'(1);
                    k_next   = k_reg + TOTAL_W'(1);
                    j_next   = '0;
                end
            end
            S_RB_NEXT: begin
                if (wok) begin
                    if (j_reg < cnt_reg) begin
                        pd_re = 1'b1;
                    end else if (push_b_reg) begin
                        pb_next      = b_reg;
                        push_b_next  = 1'b0;
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = list_index(worker_reg, b_reg.cls);
                    end
                end
            end
            S_RB_LATCH: begin
                pb_next      = prd;
                j_next       = j_reg + PCNT_W'(1);
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = list_index(worker_reg, prd.cls);
            end
            S_RB_WR: begin
                if (md.count < CNT_W'(LIST_DEPTH)) begin
                    st_we        = 1'b1;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = l_push;
                    mreq.wr_data = '{head: md.head, count: md.count + CNT_W'(1)};
                end else if (free_reg) begin
                    status_next = ST_LIST_FULL;
                end
            end
            S_EMIT_ONE: begin
                out_load = out_free;
            end
            S_OUT_RD: begin
                pd_re = 1'b1;
            end
            S_OUT_WAIT: begin
                out_load   = out_free;
                out_status = ST_OK;
                out_blk    = prd;
                out_last   = out_is_last;
                if (out_free) begin
                    j_next = j_reg + PCNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= CAP_RESET;
            align_reg   <= ALIGN_RESET;
            maxb_reg    <= MAXB_RESET;
            actw_reg    <= ACTW_RESET;
            hp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hp_reg    <= hp_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_CAPACITY:   cap_reg   <= cfg_data;
                    CFG_ALIGNMENT:  align_reg <= cfg_data[ALIGN_W-1:0];
                    CFG_MAX_BLOCKS: maxb_reg  <= cfg_data[MAXB_W-1:0];
                    CFG_WORKERS:    actw_reg  <= cfg_data[ACTW_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        worker_reg <= worker_next;
        free_reg   <= free_next;
        full_reg   <= full_next;
        rest_reg   <= rest_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        j_reg      <= j_next;
        pw_reg     <= pw_next;
        probe_reg  <= probe_next;
        cls_reg    <= cls_next;
        b_reg      <= b_next;
        pb_reg     <= pb_next;
        push_b_reg <= push_b_next;
        status_reg <= status_next;
        if (out_load) begin
            m_status_reg <= out_status;
            m_off_reg    <= out_blk.off;
            m_size_reg   <= out_blk.size;
            m_cls_reg    <= out_blk.cls;
            m_last_reg   <= out_last;
            m_rem_reg    <= (hp_reg >= {1'b0, cap_reg}) ? '0 : room[CAP_W-1:0];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_block_offset_out = m_off_reg;
    assign m_block_size_out   = m_size_reg;
    assign m_class_out        = m_cls_reg;
    assign m_last             = m_last_reg;
    assign m_remaining_space  = m_rem_reg;

endmodule

/* src/scba_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module scba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/scba_meta.sv */
// Free-list head and count memory with per-list valid bits cleared at reset.
module scba_meta
    import scba_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  meta_req_t req,
    output meta_t     rdata
);

    meta_t             mem [0:LIST_N-1];
    logic [LIST_N-1:0] vld_reg;
    meta_t             rd_reg;
    logic              rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

/* src/scba_align.sv */
// Table of heap sizes per class, rounded up to the alignment by a serial divider.
module scba_align
    import scba_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ALIGN_W-1:0] alignment,
    input  logic [CLS_W-1:0]   cls,
    output logic [SIZE_W-1:0]  asz,
    output logic               ready
);

    align_state_t       state_reg, state_next;
    logic [SIZE_W-1:0]  tbl_reg [0:NUM_CLASSES-1];
    logic [CLS_W-1:0]   idx_reg, idx_next;
    logic [4:0]         bit_reg, bit_next;
    logic [SIZE_W-1:0]  num_reg, num_next;
    logic [ALIGN_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0]  quo_reg, quo_next;
    logic [ALIGN_W-1:0] a_reg, a_next;
    logic [ALIGN_W:0]   trial;
    logic               take;
    logic [ALIGN_W-1:0] a_eff;
    logic [SIZE_W+ALIGN_W-1:0] prod;
    logic               tbl_we;

    assign a_eff = (alignment == '0) ? ALIGN_W'(DEF_ALIGN) : alignment;
    assign trial = {rem_reg, num_reg[SIZE_W-1]};
    assign take  = trial >= {1'b0, a_reg};
    assign prod  = quo_reg * a_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            AL_LOAD: state_next = AL_DIV;
            AL_DIV:  state_next = (bit_reg == '0) ? AL_MUL : AL_DIV;
            AL_MUL:  state_next = (idx_reg == CLS_W'(NUM_CLASSES - 1)) ? AL_DONE : AL_DIV;
            AL_DONE: state_next = AL_DONE;
            default: state_next = AL_LOAD;
        endcase
        if (start) begin
            state_next = AL_LOAD;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        bit_next = bit_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        a_next   = a_reg;
        tbl_we   = 1'b0;
        unique case (state_reg)
            AL_LOAD: begin
                a_next   = a_eff;
                idx_next = '0;
                bit_next = 5'(SIZE_W - 1);
                num_next = SIZE_W'(class_size('0)) + SIZE_W'(a_eff) - SIZE_W'(1);
                rem_next = '0;
                quo_next = '0;
            end
            AL_DIV: begin
                num_next = {num_reg[SIZE_W-2:0], 1'b0};
                rem_next = take ? ALIGN_W'(trial - {1'b0, a_reg}) : trial[ALIGN_W-1:0];
                quo_next = {quo_reg[SIZE_W-2:0], take};
                bit_next = bit_reg - 5'd1;
            end
            AL_MUL: begin
                tbl_we   = 1'b1;
                idx_next = idx_reg + CLS_W'(1);
                bit_next = 5'(SIZE_W - 1);
                num_next = SIZE_W'(class_size(idx_reg + CLS_W'(1))) + SIZE_W'(a_reg)
                           - SIZE_W'(1);
                rem_next = '0;
                quo_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AL_LOAD;
        end else begin
            state_reg <= state_next;
        end
        idx_reg <= idx_next;
        bit_reg <= bit_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        a_reg   <= a_next;
        if (tbl_we) begin
            tbl_reg[idx_reg] <= prod[SIZE_W-1:0];
        end
    end

    assign asz   = tbl_reg[cls];
    assign ready = (state_reg == AL_DONE) && !start;

endmodule
